### rtl/rotating_target_pattern_tracker_assert.svh
// Assertion macros used by the checker of the tracker.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef ROTATING_TARGET_PATTERN_TRACKER_ASSERT_SVH
`define ROTATING_TARGET_PATTERN_TRACKER_ASSERT_SVH

// Same-cycle implication.
`define RTPT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rtpt assertion failed");

// Next-cycle implication.
`define RTPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rtpt assertion failed");

`endif

### rtl/rtpt_pkg.sv
package rtpt_pkg;

  localparam int PlateCountW = 2;
  localparam int PlateIdW    = 4;
  localparam int RateW       = 24;
  localparam int LimitW      = 23;
  localparam int NeededW     = 15;
  localparam int TurnW       = 16;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 23;

  typedef enum logic [1:0] {
    PatA  = 2'd0,
    PatB  = 2'd1,
    PatAb = 2'd2,
    PatBa = 2'd3
  } pattern_e;

  typedef enum logic {
    DirCw  = 1'b0,
    DirCcw = 1'b1
  } dir_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgActiveRate   = 2'd0,
    CfgInactiveRate = 2'd1,
    CfgTurnsNeeded  = 2'd2
  } cfg_idx_e;

  localparam logic [PlateCountW-1:0] CountOne = 2'd1;
  localparam logic [PlateCountW-1:0] CountTwo = 2'd2;

  localparam logic [LimitW-1:0]  ActiveRateReset   = 23'd4096;
  localparam logic [LimitW-1:0]  InactiveRateReset = 23'd2048;
  localparam logic [NeededW-1:0] TurnsNeededReset  = 15'd2;

  typedef struct packed {
    logic [LimitW-1:0]  active_limit;
    logic [LimitW-1:0]  inactive_limit;
    logic [NeededW-1:0] turns_needed;
  } cfg_t;

  typedef struct packed {
    pattern_e                 pattern;
    dir_e                     dir;
    logic [TurnW-1:0]         turn_total;
    logic signed [TurnW-1:0]  turn_active;
  } track_t;

  typedef struct packed {
    pattern_e                 pattern_now;
    dir_e                     direction_now;
    logic signed [TurnW-1:0]  quarter_turns;
    logic signed [TurnW-1:0]  active_turns;
    logic                     spin_active;
  } result_t;

endpackage

### rtl/rtpt_if.sv
interface rtpt_in_if;
  logic                                    valid;
  logic                                    ready;
  logic        [rtpt_pkg::PlateCountW-1:0] plate_count;
  logic        [rtpt_pkg::PlateIdW-1:0]    first_plate_id;
  logic        [rtpt_pkg::PlateIdW-1:0]    second_plate_id;
  logic signed [rtpt_pkg::RateW-1:0]       spin_rate;

  modport source (output valid, plate_count, first_plate_id, second_plate_id, spin_rate,
                  input ready);
  modport sink (input valid, plate_count, first_plate_id, second_plate_id, spin_rate,
                output ready);
endinterface

interface rtpt_out_if;
  logic                              valid;
  logic                              ready;
  logic        [1:0]                 pattern_now;
  logic                              direction_now;
  logic signed [rtpt_pkg::TurnW-1:0] quarter_turns;
  logic signed [rtpt_pkg::TurnW-1:0] active_turns;
  logic                              spin_active;

  modport source (output valid, pattern_now, direction_now, quarter_turns, active_turns,
                  spin_active, input ready);
  modport sink (input valid, pattern_now, direction_now, quarter_turns, active_turns,
                spin_active, output ready);
endinterface

interface rtpt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rtpt_pkg::CfgIdxW-1:0]    index;
  logic [rtpt_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/rtpt_step.sv
module rtpt_step #(
  parameter int ID_W = 4
) (
  input  rtpt_pkg::cfg_t                          cfg_i,
  input  rtpt_pkg::track_t                        track_i,
  input  logic        [rtpt_pkg::PlateCountW-1:0] prev_count_i,
  input  logic        [ID_W-1:0]                  prev_first_id_i,
  input  logic        [ID_W-1:0]                  prev_second_id_i,
  input  logic        [rtpt_pkg::PlateCountW-1:0] plate_count_i,
  input  logic        [rtpt_pkg::PlateIdW-1:0]    first_plate_id_i,
  input  logic        [rtpt_pkg::PlateIdW-1:0]    second_plate_id_i,
  input  logic signed [rtpt_pkg::RateW-1:0]       spin_rate_i,
  output rtpt_pkg::track_t                        track_o,
  output logic        [rtpt_pkg::PlateCountW-1:0] prev_count_o,
  output logic        [ID_W-1:0]                  prev_first_id_o,
  output logic        [ID_W-1:0]                  prev_second_id_o,
  output rtpt_pkg::result_t                       result_o
);

  localparam int TurnW = rtpt_pkg::TurnW;
  localparam logic signed [TurnW-1:0] TurnMax = {1'b0, {(TurnW-1){1'b1}}};
  localparam logic signed [TurnW-1:0] TurnMin = {1'b1, {(TurnW-1){1'b0}}};

  function automatic logic [TurnW:0] abs_turn(logic signed [TurnW-1:0] v);
    logic [TurnW:0] ext;
    ext = {v[TurnW-1], v};
    return v[TurnW-1] ? (~ext + 1'b1) : ext;
  endfunction

  logic                 count_ok;
  logic [ID_W-1:0]      id0;
  logic [ID_W-1:0]      id1;
  logic [rtpt_pkg::RateW-1:0] mag;
  logic                 above_inactive;
  logic                 above_active;
  logic [TurnW:0]       needed_ext;
  logic                 pre_active;
  logic                 step_up;
  logic                 step_down;
  rtpt_pkg::dir_e       dir_d;
  rtpt_pkg::pattern_e   pattern_d;
  logic [TurnW-1:0]     total_d;
  logic signed [TurnW-1:0] active_step;
  logic signed [TurnW-1:0] active_d;
  rtpt_pkg::track_t     next_track;

  assign count_ok = (plate_count_i == rtpt_pkg::CountOne) ||
                    (plate_count_i == rtpt_pkg::CountTwo);
  assign id0 = first_plate_id_i[ID_W-1:0];
  assign id1 = second_plate_id_i[ID_W-1:0];

  // magnitude of the most negative rate still fits unsigned
  assign mag = spin_rate_i[rtpt_pkg::RateW-1] ? (~spin_rate_i + 1'b1) : spin_rate_i;
  assign above_inactive = mag > {1'b0, cfg_i.inactive_limit};
  assign above_active   = mag > {1'b0, cfg_i.active_limit};
  assign needed_ext     = {2'b00, cfg_i.turns_needed};

  assign pre_active = above_inactive && (abs_turn(track_i.turn_active) >= needed_ext);

  always_comb begin
    dir_d = track_i.dir;
    if (prev_count_i == rtpt_pkg::CountOne && plate_count_i == rtpt_pkg::CountTwo) begin
      if (prev_first_id_i == id0) dir_d = rtpt_pkg::DirCw;
      else if (prev_first_id_i == id1) dir_d = rtpt_pkg::DirCcw;
    end else if (prev_count_i == rtpt_pkg::CountTwo &&
                 plate_count_i == rtpt_pkg::CountOne) begin
      if (prev_first_id_i == id0) dir_d = rtpt_pkg::DirCcw;
      else if (prev_second_id_i == id0) dir_d = rtpt_pkg::DirCw;
    end
  end

  always_comb begin
    pattern_d = track_i.pattern;
    step_up   = 1'b0;
    step_down = 1'b0;
    if (plate_count_i == rtpt_pkg::CountOne) begin
      case (track_i.pattern)
        rtpt_pkg::PatAb: begin
          if (dir_d == rtpt_pkg::DirCcw) pattern_d = rtpt_pkg::PatA;
          else begin
            pattern_d = rtpt_pkg::PatB;
            step_down = 1'b1;
          end
        end
        rtpt_pkg::PatBa: begin
          if (dir_d == rtpt_pkg::DirCcw) pattern_d = rtpt_pkg::PatB;
          else begin
            pattern_d = rtpt_pkg::PatA;
            step_down = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (plate_count_i == rtpt_pkg::CountTwo) begin
      case (track_i.pattern)
        rtpt_pkg::PatA: begin
          if (dir_d == rtpt_pkg::DirCcw) begin
            pattern_d = rtpt_pkg::PatBa;
            step_up   = 1'b1;
          end else pattern_d = rtpt_pkg::PatAb;
        end
        rtpt_pkg::PatB: begin
          if (dir_d == rtpt_pkg::DirCcw) begin
            pattern_d = rtpt_pkg::PatAb;
            step_up   = 1'b1;
          end else pattern_d = rtpt_pkg::PatBa;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    total_d     = track_i.turn_total;
    active_step = track_i.turn_active;
    if (step_up) begin
      total_d = track_i.turn_total + 1'b1;
      if (track_i.turn_active != TurnMax) active_step = track_i.turn_active + 1'b1;
    end else if (step_down) begin
      total_d = track_i.turn_total - 1'b1;
      if (track_i.turn_active != TurnMin) active_step = track_i.turn_active - 1'b1;
    end
    // hysteresis, judged on the count before this frame's step
    if (pre_active ? !above_inactive : !above_active) active_d = '0;
    else active_d = active_step;
  end

  always_comb begin
    next_track.pattern     = pattern_d;
    next_track.dir         = dir_d;
    next_track.turn_total  = total_d;
    next_track.turn_active = active_d;
  end

  assign track_o          = count_ok ? next_track : track_i;
  assign prev_count_o     = count_ok ? plate_count_i : prev_count_i;
  assign prev_first_id_o  = count_ok ? id0 : prev_first_id_i;
  assign prev_second_id_o = count_ok ? ((plate_count_i == rtpt_pkg::CountTwo) ? id1 : '0)
                                     : prev_second_id_i;

  assign result_o.pattern_now   = track_o.pattern;
  assign result_o.direction_now = track_o.dir;
  assign result_o.quarter_turns = track_o.turn_total;
  assign result_o.active_turns  = track_o.turn_active;
  assign result_o.spin_active   = above_inactive &&
                                  (abs_turn(track_o.turn_active) >= needed_ext);

endmodule

### rtl/rotating_target_pattern_tracker.sv
// A result passes through the input register and then the result register before it is valid.
// Throughput: one item per clock while the output is not stalled; the tracker state is updated
// as an item moves from the input register to the result register, so the next item sees it.
// While a result waits on a stalled output the input register takes one more item, then
// the input stalls until the result is taken.
// Reset (rst_ni, async, active low): tracker state cleared, registers to defaults, no valid.
module rotating_target_pattern_tracker #(
  parameter int ID_WIDTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rtpt_in_if.sink           in_i,
  rtpt_out_if.source        out_o,
  rtpt_cfg_if.sink          cfg_i
);

  localparam int IdW = (ID_WIDTH < rtpt_pkg::PlateIdW) ? ID_WIDTH : rtpt_pkg::PlateIdW;

  rtpt_pkg::cfg_t cfg_q;

  logic                                    s1_valid_q;
  logic        [rtpt_pkg::PlateCountW-1:0] s1_count_q;
  logic        [rtpt_pkg::PlateIdW-1:0]    s1_id0_q;
  logic        [rtpt_pkg::PlateIdW-1:0]    s1_id1_q;
  logic signed [rtpt_pkg::RateW-1:0]       s1_rate_q;

  rtpt_pkg::track_t                  track_q, track_d;
  logic [rtpt_pkg::PlateCountW-1:0]  prev_count_q, prev_count_d;
  logic [IdW-1:0]                    prev_first_q, prev_first_d;
  logic [IdW-1:0]                    prev_second_q, prev_second_d;

  logic              out_valid_q;
  rtpt_pkg::result_t out_q, result_d;

  logic in_fire;
  logic s1_adv;

  assign s1_adv   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire  = in_i.valid && in_i.ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_limit   <= rtpt_pkg::ActiveRateReset;
      cfg_q.inactive_limit <= rtpt_pkg::InactiveRateReset;
      cfg_q.turns_needed   <= rtpt_pkg::TurnsNeededReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rtpt_pkg::CfgActiveRate:   cfg_q.active_limit   <= cfg_i.data;
        rtpt_pkg::CfgInactiveRate: cfg_q.inactive_limit <= cfg_i.data;
        rtpt_pkg::CfgTurnsNeeded:  cfg_q.turns_needed   <= cfg_i.data[rtpt_pkg::NeededW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_count_q <= in_i.plate_count;
      s1_id0_q   <= in_i.first_plate_id;
      s1_id1_q   <= in_i.second_plate_id;
      s1_rate_q  <= in_i.spin_rate;
    end
  end

  rtpt_step #(
    .ID_W (IdW)
  ) u_step (
    .cfg_i             (cfg_q),
    .track_i           (track_q),
    .prev_count_i      (prev_count_q),
    .prev_first_id_i   (prev_first_q),
    .prev_second_id_i  (prev_second_q),
    .plate_count_i     (s1_count_q),
    .first_plate_id_i  (s1_id0_q),
    .second_plate_id_i (s1_id1_q),
    .spin_rate_i       (s1_rate_q),
    .track_o           (track_d),
    .prev_count_o      (prev_count_d),
    .prev_first_id_o   (prev_first_d),
    .prev_second_id_o  (prev_second_d),
    .result_o          (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q.pattern     <= rtpt_pkg::PatA;
      track_q.dir         <= rtpt_pkg::DirCw;
      track_q.turn_total  <= '0;
      track_q.turn_active <= '0;
      prev_count_q        <= '0;
      prev_first_q        <= '0;
      prev_second_q       <= '0;
    end else if (s1_adv) begin
      track_q       <= track_d;
      prev_count_q  <= prev_count_d;
      prev_first_q  <= prev_first_d;
      prev_second_q <= prev_second_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= result_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pattern_now   = out_q.pattern_now;
  assign out_o.direction_now = out_q.direction_now;
  assign out_o.quarter_turns = out_q.quarter_turns;
  assign out_o.active_turns  = out_q.active_turns;
  assign out_o.spin_active   = out_q.spin_active;

endmodule

### rtl/rtpt_checker.sv
`include "rotating_target_pattern_tracker_assert.svh"

module rtpt_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic        [1:0]                 pattern_now_i,
  input logic                              direction_now_i,
  input logic signed [rtpt_pkg::TurnW-1:0] quarter_turns_i,
  input logic signed [rtpt_pkg::TurnW-1:0] active_turns_i,
  input logic                              spin_active_i
);

  // a stalled result holds its payload
  `RTPT_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    $stable(pattern_now_i) && $stable(direction_now_i) && $stable(quarter_turns_i) &&
    $stable(active_turns_i) && $stable(spin_active_i) && out_valid_i)

  // input side only backs up behind a stalled result
  `RTPT_ASSERT_NOW(a_in_stall_cause, !in_ready_i, out_valid_i && !out_ready_i)

  // a fresh result follows an input transaction through the input register and the result register
  `RTPT_ASSERT_NOW(a_out_from_in, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2))

endmodule

bind rotating_target_pattern_tracker rtpt_checker u_rtpt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .pattern_now_i   (out_o.pattern_now),
  .direction_now_i (out_o.direction_now),
  .quarter_turns_i (out_o.quarter_turns),
  .active_turns_i  (out_o.active_turns),
  .spin_active_i   (out_o.spin_active)
);
